// ===== src/dpn_pkg.sv =====
// Shared types and constants for the permessage-deflate offer negotiator.
// Holds the result record, register indexes and the keyword text tables.
// No dependencies.
`default_nettype none

package dpn_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_COMPRESSION_ENABLED = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_BITS_LIMIT   = 4'd1;

    localparam logic [3:0] WINDOW_BITS_RESET = 4'd15;
    localparam logic [3:0] WINDOW_BITS_MIN   = 4'd8;
    localparam logic [3:0] WINDOW_BITS_MAX   = 4'd15;

    // Extension name
    localparam logic [4:0]          EXT_LEN  = 5'd18;
    localparam logic [18*8-1:0]     EXT_TEXT = "permessage-deflate";

    // Parameter names
    localparam logic [1:0] PARAM_SNC   = 2'd0;
    localparam logic [1:0] PARAM_CNC   = 2'd1;
    localparam logic [1:0] PARAM_SBITS = 2'd2;
    localparam logic [1:0] PARAM_CBITS = 2'd3;

    // Parameter names are a side prefix joined to a common tail
    localparam logic [6*8-1:0]  SIDE_SERVER = "server";
    localparam logic [6*8-1:0]  SIDE_CLIENT = "client";
    localparam logic [20*8-1:0] NOCTX_TAIL  = "_no_context_takeover";
    localparam logic [16*8-1:0] WBITS_TAIL  = "_max_window_bits";

    localparam logic [26*8-1:0] SNC_TEXT   = {SIDE_SERVER, NOCTX_TAIL};
    localparam logic [26*8-1:0] CNC_TEXT   = {SIDE_CLIENT, NOCTX_TAIL};
    localparam logic [22*8-1:0] SBITS_TEXT = {SIDE_SERVER, WBITS_TAIL};
    localparam logic [22*8-1:0] CBITS_TEXT = {SIDE_CLIENT, WBITS_TAIL};

    // ASCII codes the parser keys on
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic       offer_found;
        logic       agreed;
        logic       server_noctx_offered;
        logic       client_noctx_offered;
        logic       client_bits_in_reply;
        logic [3:0] client_bits_reply;
        logic       server_bits_in_reply;
        logic [3:0] server_bits_reply;
        logic       value_error;
    } dpn_result_t;

    // Length of a parameter name
    function automatic logic [4:0] param_len(input logic [1:0] sel);
        logic [4:0] len;
        case (sel)
            PARAM_SNC:   len = 5'd26;
            PARAM_CNC:   len = 5'd26;
            PARAM_SBITS: len = 5'd22;
            default:     len = 5'd22;
        endcase
        return len;
    endfunction

    // Character of a parameter name; pos must be below param_len(sel)
    function automatic logic [7:0] param_char(input logic [1:0] sel, input logic [4:0] pos);
        logic [7:0] ch;
        int         k;
        k = int'(param_len(sel)) - 1 - int'(pos);
        if (k < 0)
        begin
            k = 0;
        end
        case (sel)
            PARAM_SNC:   ch = SNC_TEXT[k*8 +: 8];
            PARAM_CNC:   ch = CNC_TEXT[k*8 +: 8];
            PARAM_SBITS: ch = SBITS_TEXT[k*8 +: 8];
            default:     ch = CBITS_TEXT[k*8 +: 8];
        endcase
        return ch;
    endfunction

    // Character of the extension name; pos must be below EXT_LEN
    function automatic logic [7:0] ext_char(input logic [4:0] pos);
        int k;
        k = int'(EXT_LEN) - 1 - int'(pos);
        if (k < 0)
        begin
            k = 0;
        end
        return EXT_TEXT[k*8 +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== src/dpn_parser.sv =====
// Byte parser of the extensions header: name search, parameter split,
// value reading and reply computation. Uses dpn_pkg.
// Holds the running parse state; result is combinational on the last byte.
`default_nettype none

module dpn_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [7:0]         hdr_byte,
    input  wire logic               last_byte,
    input  wire logic               compression_enabled,
    input  wire logic [3:0]         window_bits_limit,
    output dpn_pkg::dpn_result_t    result
);
    import dpn_pkg::*;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_SUFFIX,
        PH_PARAMS,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        SP_WAIT,
        SP_NAME,
        SP_TRAIL,
        SP_VEMPTY,
        SP_VWS,
        SP_VNUM,
        SP_VDONE
    } sub_t;

    typedef struct packed {
        phase_t            phase;
        logic [4:0]        name_pos;
        logic              prefix_ok;
        logic [3:0]        cand;
        logic [4:0]        char_pos;
        sub_t              sub;
        logic [7:0]        accum;
        logic              neg;
        logic              digit;
        logic              found;
        logic              snc;
        logic              cnc;
        logic              sbits_seen;
        logic              cbits_seen;
        logic signed [8:0] sbits;
        logic signed [8:0] cbits;
        logic              err;
    } pstate_t;

    localparam pstate_t PS_CLEAR = '{
        phase:      PH_SEARCH,
        name_pos:   5'd0,
        prefix_ok:  1'b1,
        cand:       4'hF,
        char_pos:   5'd0,
        sub:        SP_WAIT,
        accum:      8'd0,
        neg:        1'b0,
        digit:      1'b0,
        found:      1'b0,
        snc:        1'b0,
        cnc:        1'b0,
        sbits_seen: 1'b0,
        cbits_seen: 1'b0,
        sbits:      9'sd15,
        cbits:      9'sd0,
        err:        1'b0
    };

    pstate_t ps_reg;
    pstate_t ps_next;
    pstate_t ps_work;

    // Open a new parameter after a semicolon
    function automatic pstate_t start_param(input pstate_t s);
        pstate_t r;
        r          = s;
        r.sub      = SP_NAME;
        r.cand     = 4'hF;
        r.char_pos = 5'd0;
        r.accum    = 8'd0;
        r.neg      = 1'b0;
        r.digit    = 1'b0;
        return r;
    endfunction

    // Close the current parameter and record what it carried
    function automatic pstate_t finish_param(input pstate_t s);
        pstate_t           r;
        logic              empty;
        logic signed [8:0] val;
        logic              sel_ok;
        logic [1:0]        sel;
        r      = s;
        empty  = (s.sub == SP_NAME) || (s.sub == SP_TRAIL) || (s.sub == SP_VEMPTY);
        val    = s.neg ? -$signed({1'b0, s.accum}) : $signed({1'b0, s.accum});
        sel_ok = 1'b0;
        sel    = PARAM_SNC;
        for (int i = 0; i < 4; i++)
        begin
            if (s.cand[i] && (s.char_pos == param_len(2'(i))))
            begin
                sel_ok = 1'b1;
                sel    = 2'(i);
            end
        end
        if (sel_ok)
        begin
            case (sel)
                PARAM_SNC:
                begin
                    r.snc = 1'b1;
                end
                PARAM_CNC:
                begin
                    r.cnc = 1'b1;
                end
                PARAM_SBITS:
                begin
                    r.sbits_seen = 1'b1;
                    if (!empty)
                    begin
                        if (s.digit)
                        begin
                            r.sbits = val;
                        end
                        else
                        begin
                            r.err = 1'b1;
                        end
                    end
                end
                default:
                begin
                    r.cbits_seen = 1'b1;
                    if (empty)
                    begin
                        r.cbits = 9'sd0;
                    end
                    else if (s.digit)
                    begin
                        r.cbits = val;
                    end
                    else
                    begin
                        r.err = 1'b1;
                    end
                end
            endcase
        end
        return r;
    endfunction

    // Cap by the limit, then clamp to the legal window range
    function automatic logic [3:0] reply_bits(input logic signed [8:0] v,
                                              input logic [3:0] lim);
        logic signed [8:0] r;
        logic signed [8:0] lim_s;
        lim_s = $signed({5'd0, lim});
        r     = (v < lim_s) ? v : lim_s;
        if (r < $signed({5'd0, WINDOW_BITS_MIN}))
        begin
            r = $signed({5'd0, WINDOW_BITS_MIN});
        end
        if (r > $signed({5'd0, WINDOW_BITS_MAX}))
        begin
            r = $signed({5'd0, WINDOW_BITS_MAX});
        end
        return r[3:0];
    endfunction

    // Decimal value digits, saturating at 255
    function automatic pstate_t value_byte(input pstate_t s, input logic [7:0] b);
        pstate_t     r;
        logic        is_digit;
        logic        is_ws;
        logic [11:0] v;
        r        = s;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        is_ws    = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
        v        = {1'b0, s.accum, 3'b000} + {3'b000, s.accum, 1'b0} + {8'd0, b[3:0]};
        case (s.sub)
            SP_VNUM:
            begin
                if (is_digit)
                begin
                    r.accum = (v > 12'd255) ? 8'd255 : v[7:0];
                    r.digit = 1'b1;
                end
                else
                begin
                    r.sub = SP_VDONE;
                end
            end
            SP_VDONE:
            begin
                r = s;
            end
            default:
            begin
                if (b == CH_SPACE)
                begin
                    r = s;
                end
                else if (is_ws)
                begin
                    r.sub = SP_VWS;
                end
                else if ((b == CH_PLUS) || (b == CH_MINUS))
                begin
                    if (b == CH_MINUS)
                    begin
                        r.neg = 1'b1;
                    end
                    r.sub = SP_VNUM;
                end
                else if (is_digit)
                begin
                    r.accum = {4'd0, b[3:0]};
                    r.digit = 1'b1;
                    r.sub   = SP_VNUM;
                end
                else
                begin
                    r.sub = SP_VDONE;
                end
            end
        endcase
        return r;
    endfunction

    // Parameter section: split at semicolons, match names, read values
    function automatic pstate_t param_byte(input pstate_t s, input logic [7:0] b);
        pstate_t r;
        r = s;
        if (s.sub == SP_WAIT)
        begin
            if (b == CH_SEMI)
            begin
                r = start_param(s);
            end
            else if (b == CH_COMMA)
            begin
                r.phase = PH_DONE;
            end
        end
        else if (b == CH_SEMI)
        begin
            r = start_param(finish_param(s));
        end
        else if (b == CH_COMMA)
        begin
            r       = finish_param(s);
            r.phase = PH_DONE;
        end
        else if ((s.sub == SP_NAME) || (s.sub == SP_TRAIL))
        begin
            if (b == CH_EQ)
            begin
                r.sub   = SP_VEMPTY;
                r.accum = 8'd0;
                r.neg   = 1'b0;
                r.digit = 1'b0;
            end
            else if (b == CH_SPACE)
            begin
                if ((s.sub == SP_NAME) && (s.char_pos != 5'd0))
                begin
                    r.sub = SP_TRAIL;
                end
            end
            else if (s.sub == SP_TRAIL)
            begin
                r.cand = 4'h0;
                r.sub  = SP_NAME;
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (!((s.char_pos < param_len(2'(i))) &&
                          (param_char(2'(i), s.char_pos) == b)))
                    begin
                        r.cand[i] = 1'b0;
                    end
                end
                if (s.char_pos != 5'd31)
                begin
                    r.char_pos = s.char_pos + 5'd1;
                end
            end
        end
        else
        begin
            r = value_byte(s, b);
        end
        return r;
    endfunction

    // Advance the parse state by one byte and close out on the last one
    always_comb
    begin
        ps_work = ps_reg;
        case (ps_reg.phase)
            PH_SEARCH:
            begin
                if (ps_reg.name_pos != 5'd0)
                begin
                    if ((ps_reg.name_pos < EXT_LEN) && (ext_char(ps_reg.name_pos) == hdr_byte))
                    begin
                        ps_work.name_pos = ps_reg.name_pos + 5'd1;
                    end
                    else
                    begin
                        ps_work.name_pos = 5'd0;
                    end
                end
                else if (ps_reg.prefix_ok && (hdr_byte == "p"))
                begin
                    ps_work.name_pos = 5'd1;
                end
                ps_work.prefix_ok = (hdr_byte == CH_COMMA) || (hdr_byte == CH_SPACE);
                if (ps_work.name_pos >= EXT_LEN)
                begin
                    ps_work.phase = PH_SUFFIX;
                end
            end
            PH_SUFFIX:
            begin
                if ((hdr_byte == CH_SEMI) || (hdr_byte == CH_COMMA) || (hdr_byte == CH_SPACE))
                begin
                    ps_work.found = 1'b1;
                    ps_work.phase = PH_PARAMS;
                    ps_work.sub   = SP_WAIT;
                    if (hdr_byte == CH_SEMI)
                    begin
                        ps_work = start_param(ps_work);
                    end
                    else if (hdr_byte == CH_COMMA)
                    begin
                        ps_work.phase = PH_DONE;
                    end
                end
                else
                begin
                    ps_work.phase     = PH_SEARCH;
                    ps_work.name_pos  = 5'd0;
                    ps_work.prefix_ok = 1'b0;
                end
            end
            PH_PARAMS:
            begin
                ps_work = param_byte(ps_reg, hdr_byte);
            end
            default:
            begin
                ps_work = ps_reg;
            end
        endcase

        if (last_byte)
        begin
            if (ps_work.phase == PH_SUFFIX)
            begin
                ps_work.found = 1'b1;
            end
            else if ((ps_work.phase == PH_PARAMS) && (ps_work.sub != SP_WAIT))
            begin
                ps_work = finish_param(ps_work);
            end
        end

        ps_next = last_byte ? PS_CLEAR : ps_work;
    end

    // Build the reply from the closed-out state
    always_comb
    begin
        result.offer_found          = ps_work.found;
        result.agreed               = ps_work.found && compression_enabled;
        result.server_noctx_offered = ps_work.snc;
        result.client_noctx_offered = ps_work.cnc;
        result.client_bits_in_reply = result.agreed && ps_work.cbits_seen;
        result.server_bits_in_reply = result.agreed && ps_work.sbits_seen;
        result.value_error          = ps_work.err;
        result.client_bits_reply    = 4'd0;
        result.server_bits_reply    = 4'd0;
        if (result.client_bits_in_reply)
        begin
            if (ps_work.cbits == 9'sd0)
            begin
                result.client_bits_reply = reply_bits($signed({5'd0, window_bits_limit}),
                                                      window_bits_limit);
            end
            else
            begin
                result.client_bits_reply = reply_bits(ps_work.cbits, window_bits_limit);
            end
        end
        if (result.server_bits_in_reply)
        begin
            result.server_bits_reply = reply_bits(ps_work.sbits, window_bits_limit);
        end
    end

    // Hold parse state; advance on each consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg <= PS_CLEAR;
        end
        else if (step)
        begin
            ps_reg <= ps_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/deflate_extension_offer_negotiator.sv =====
// Path: the input register captures each accepted byte, and the result register
// captures the result when the last byte is consumed from the input register.
// Throughput: one header byte per cycle, set by the single-pass byte parser
// between the two registers; a result stalled at the output blocks only a
// following last byte.
// Reset: asynchronous, active low; clears the parse state, both pipeline valids,
// and sets compression off with a window bits limit of 15.
// Top level: handshakes, configuration registers and result register.
// Uses dpn_pkg and dpn_parser.
`default_nettype none

module deflate_extension_offer_negotiator (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [7:0]                       hdr_byte,
    input  wire logic                             last_byte,
    // configuration channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dpn_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [dpn_pkg::CFG_DATA_W-1:0]   cfg_data,
    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  offer_found,
    output logic                                  agreed,
    output logic                                  server_noctx_offered,
    output logic                                  client_noctx_offered,
    output logic                                  client_bits_in_reply,
    output logic [3:0]                            client_bits_reply,
    output logic                                  server_bits_in_reply,
    output logic [3:0]                            server_bits_reply,
    output logic                                  value_error
);
    import dpn_pkg::*;

    logic        compression_reg;
    logic [3:0]  limit_reg;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        s1_adv;
    logic        in_accept;

    logic        out_valid_reg;
    logic        out_valid_next;
    dpn_result_t out_reg;
    dpn_result_t parse_result;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compression_reg <= 1'b0;
            limit_reg       <= WINDOW_BITS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COMPRESSION_ENABLED: compression_reg <= cfg_data[0];
                REG_WINDOW_BITS_LIMIT:   limit_reg       <= cfg_data[3:0];
                default:                 ;
            endcase
        end
    end

    // Consume the staged byte unless its result has nowhere to go
    assign s1_adv    = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    dpn_parser u_parser (
        .clk                 (clk),
        .rst_n               (rst_n),
        .step                (s1_adv),
        .hdr_byte            (s1_byte_reg),
        .last_byte           (s1_last_reg),
        .compression_enabled (compression_reg),
        .window_bits_limit   (limit_reg),
        .result              (parse_result)
    );

    // Hold pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= hdr_byte;
            s1_last_reg <= last_byte;
        end
        if (s1_adv && s1_last_reg)
        begin
            out_reg <= parse_result;
        end
    end

    assign out_valid            = out_valid_reg;
    assign offer_found          = out_reg.offer_found;
    assign agreed               = out_reg.agreed;
    assign server_noctx_offered = out_reg.server_noctx_offered;
    assign client_noctx_offered = out_reg.client_noctx_offered;
    assign client_bits_in_reply = out_reg.client_bits_in_reply;
    assign client_bits_reply    = out_reg.client_bits_reply;
    assign server_bits_in_reply = out_reg.server_bits_in_reply;
    assign server_bits_reply    = out_reg.server_bits_reply;
    assign value_error          = out_reg.value_error;

    // A last byte never overwrites a result still waiting at the output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_last_reg) |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while stalled");

    // A consumed last byte always produces a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_last_reg) |=> out_valid)
        else $error("last byte consumed without result");

    // The input stalls only behind a last byte blocked by a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_last_reg && out_valid_reg && out_stall))
        else $error("input stalled without cause");

    // An agreed reply implies an offer was found
    a_agreed_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && agreed) |-> offer_found)
        else $error("agreed without offer");

endmodule

`default_nettype wire
